@@ src/sbr_pkg.sv @@
package sbr_pkg;

  // Microframe masks are one byte wide; a bit index into them needs three bits.
  localparam int MASK_W = 8;
  localparam int BIT_W  = 3;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_UNSUP  = 2'd1,
    ST_NOROOM = 2'd2
  } status_t;

  // Request modes.
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_FRAMES    = 2'd1;
  localparam logic [1:0] REG_SUBFRAMES = 2'd2;
  localparam logic [1:0] REG_MAXBW     = 2'd3;

  // Handshake between the sequencer and the remainder unit.
  typedef struct packed {
    logic start;
    logic done;
  } mod_ctl_t;

  // Mask with every bit below n set; n of eight or more gives all ones.
  function automatic logic [MASK_W-1:0] low_mask(input logic [3:0] n);
    logic [15:0] m;
    begin
      m = (16'd1 << n) - 16'd1;
      return m[MASK_W-1:0];
    end
  endfunction

endpackage

@@ src/sbr_mod.sv @@
module sbr_mod
  import sbr_pkg::*;
#(
  parameter int DW = 12,
  parameter int FW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  mod_ctl_t      ctl_in,
  input  logic [DW-1:0] dividend,
  input  logic [FW-1:0] divisor,
  output mod_ctl_t      ctl_out,
  output logic [FW-1:0] rem
);

  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic          run;
  logic [CW-1:0] cnt;
  logic [DW-1:0] shreg;
  logic [FW:0]   trial;

  // One dividend bit enters the partial remainder per cycle.
  assign trial = {rem, shreg[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      ctl_out <= '0;
    end else begin
      ctl_out.done <= 1'b0;
      ctl_out.start <= 1'b0;
      if (ctl_in.start) begin
        shreg <= dividend;
        rem <= '0;
        cnt <= CW'(DW - 1);
        run <= 1'b1;
      end else if (run) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= FW'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[FW-1:0];
        end
        shreg <= shreg << 1;
        cnt <= cnt - CW'(1);
        if (cnt == '0) begin
          run <= 1'b0;
          ctl_out.done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/split_bandwidth_reserver.sv @@
// Split-transaction bandwidth reserver for a periodic schedule.
//
// A request is taken when start is high and busy is low. Mode allocate searches
// frames, then start microframes, for a run of start-split slots plus an optional
// complete-split window, checks every occurrence at the interval against
// max_bandwidth, and commits both phases. Mode free subtracts the costs again,
// saturating each slot at zero. Each request gives one result on the result
// ports, marked by done for exactly one cycle; the receiver cannot hold it off.
// Configuration is written through wr_en, wr_index and wr_data; the user must
// write it only while idle; the block itself leaves this unchecked.
//
// Table access: the load table is one single-port memory, and every slot visit
// is a read followed by a check or a write. An allocate checks every occurrence
// for each candidate, then visits every occurrence again to commit. A free uses
// the serial remainder unit to find the completion frame of each occurrence,
// then releases the start slots and the complete slots. Rejected requests are
// answered from the idle state without busy going high. After reset the table
// is cleared, one entry per cycle, with busy high.
module split_bandwidth_reserver
  import sbr_pkg::*;
#(
  parameter int MAX_FRAMES    = 1024,
  parameter int MAX_SUBFRAMES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [7:0]  interval,
  input  logic [7:0]  start_cost,
  input  logic [7:0]  complete_cost,
  input  logic [3:0]  start_runs,
  input  logic        needs_complete,
  input  logic [9:0]  first_frame,
  input  logic [7:0]  start_mask_in,
  input  logic [7:0]  complete_mask_in,
  input  logic [9:0]  frame_offset_in,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [10:0] wr_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [9:0]  chosen_frame,
  output logic [7:0]  interval_used,
  output logic [7:0]  start_mask,
  output logic [7:0]  complete_mask,
  output logic        frame_offset
);

  localparam int FW    = ($clog2(MAX_FRAMES + 1) > 11) ? $clog2(MAX_FRAMES + 1) : 11;
  localparam int DW    = FW + 1;
  localparam int DEPTH = MAX_FRAMES * MAX_SUBFRAMES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = FW + 4;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CAND, S_CRD, S_CCK, S_WRD, S_WWR, S_FMOD, S_FRD, S_FWR
  } state_t;

  state_t state;

  // Configuration registers.
  logic        periodic_enable;
  logic [10:0] frame_count;
  logic [3:0]  subframe_count;
  logic [7:0]  max_bandwidth;

  // Latched item.
  logic [7:0]  iv;
  logic [7:0]  scost;
  logic [7:0]  ccost;
  logic [3:0]  runs;
  logic        needc;
  logic [7:0]  smask;
  logic [7:0]  cmask;
  logic [9:0]  off;
  logic        carry;

  // Sequencer counters.
  logic [FW-1:0]    fr;
  logic [3:0]       st;
  logic [FW-1:0]    occ;
  logic [FW-1:0]    cf;
  logic [BIT_W-1:0] b;
  logic             phase;
  logic [AW-1:0]    clr_addr;

  // Load table.
  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic [7:0]    rdata;

  // Remainder unit.
  mod_ctl_t      mctl;
  mod_ctl_t      mstat;
  logic [DW-1:0] dividend;
  logic [FW-1:0] mod_rem;

  // Derived values.
  logic [FW-1:0]  f_eff;
  logic           sub_ok;
  logic [7:0]     cand_s;
  logic [7:0]     cand_c;
  logic [4:0]     st_end;
  logic           b_last;
  logic [FW:0]    occ_sum;
  logic           occ_end;
  logic [FW-1:0]  sel_frame;
  logic [PW-1:0]  row;
  logic [8:0]     load_s;
  logic [8:0]     load_c;
  logic           fail;
  logic           bit_s;
  logic           bit_c;
  logic [7:0]     add_s;
  logic [7:0]     add_c;
  logic [7:0]     rel_cost;
  logic           rel_bit;
  logic           accept;

  assign accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign frame_offset = 1'b0;

  // Frames and microframes in use.
  always_comb begin
    f_eff = (FW'(frame_count) > FW'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(frame_count);
    sub_ok = (subframe_count >= 4'd2) && (subframe_count <= 4'(MAX_SUBFRAMES));
  end

  // Candidate masks for the current start microframe.
  always_comb begin
    logic [15:0] run_bits;
    logic [15:0] win_bits;
    logic [4:0]  win_lo;
    run_bits = ((16'd1 << runs) - 16'd1) << st;
    win_lo = 5'(st) + 5'(runs) + 5'd1;
    win_bits = 16'hFFFF << win_lo;
    st_end = 5'(st) + 5'(runs);
    cand_s = run_bits[7:0];
    cand_c = needc ? (win_bits[7:0] & low_mask(subframe_count)) : 8'd0;
  end

  // Slot walk and table address.
  always_comb begin
    b_last = (4'(b) + 4'd1) == subframe_count;
    occ_sum = (FW+1)'(occ) + (FW+1)'(iv);
    occ_end = occ_sum >= {1'b0, f_eff};
    sel_frame = ((state == S_FRD || state == S_FWR) && phase) ? cf : occ;
    row = PW'(sel_frame) * PW'(subframe_count);
    dividend = DW'(occ) + DW'(off) + DW'(carry);
  end

  // Checks and new loads from the value just read.
  always_comb begin
    bit_s = smask[b];
    bit_c = cmask[b];
    load_s = {1'b0, rdata} + {1'b0, scost};
    load_c = {1'b0, rdata} + {1'b0, ccost};
    fail = (bit_s && load_s > {1'b0, max_bandwidth}) ||
           (bit_c && load_c > {1'b0, max_bandwidth});
    add_s = bit_s ? scost : 8'd0;
    add_c = bit_c ? ccost : 8'd0;
    rel_cost = phase ? ccost : scost;
    rel_bit = phase ? bit_c : bit_s;
  end

  // Memory port control.
  always_comb begin
    mem_addr = AW'(row + PW'(b));
    mem_we = 1'b0;
    mem_wdata = 8'd0;
    case (state)
      S_CLEAR: begin
        mem_addr = clr_addr;
        mem_we = 1'b1;
      end
      S_WWR: begin
        mem_we = bit_s || bit_c;
        mem_wdata = rdata + add_s + add_c;
      end
      S_FWR: begin
        mem_we = rel_bit;
        mem_wdata = (rdata > rel_cost) ? (rdata - rel_cost) : 8'd0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Load table, one read or write per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  sbr_mod #(
    .DW(DW),
    .FW(FW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (mctl),
    .dividend (dividend),
    .divisor  (f_eff),
    .ctl_out  (mstat),
    .rem      (mod_rem)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_enable <= 1'b1;
      frame_count <= 11'd1024;
      subframe_count <= 4'd8;
      max_bandwidth <= 8'd100;
    end else if (wr_en) begin
      case (wr_index)
        REG_ENABLE:    periodic_enable <= wr_data[0];
        REG_FRAMES:    frame_count <= wr_data;
        REG_SUBFRAMES: subframe_count <= wr_data[3:0];
        REG_MAXBW:     max_bandwidth <= wr_data[7:0];
        default:       periodic_enable <= periodic_enable;
      endcase
    end
  end

  // Sequencer and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      done <= 1'b0;
      mctl <= '0;
    end else begin
      done <= 1'b0;
      mctl.start <= 1'b0;
      mctl.done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            iv <= (interval == 8'd0) ? 8'd1 : interval;
            scost <= start_cost;
            ccost <= complete_cost;
            runs <= start_runs;
            needc <= needs_complete;
            smask <= start_mask_in;
            cmask <= complete_mask_in;
            off <= frame_offset_in;
            carry <= (start_mask_in & low_mask(subframe_count)) == 8'd0;
            interval_used <= (interval == 8'd0) ? 8'd1 : interval;
            if (mode == MODE_FREE) begin
              status <= ST_OK;
              chosen_frame <= first_frame;
              start_mask <= start_mask_in;
              complete_mask <= complete_mask_in;
              if (!sub_ok || FW'(first_frame) >= f_eff) begin
                done <= 1'b1;
              end else begin
                occ <= FW'(first_frame);
                mctl.start <= 1'b1;
                state <= S_FMOD;
              end
            end else begin
              chosen_frame <= 10'd0;
              start_mask <= 8'd0;
              complete_mask <= 8'd0;
              if (!periodic_enable || !sub_ok || start_runs == 4'd0 ||
                  start_runs > subframe_count) begin
                status <= ST_UNSUP;
                done <= 1'b1;
              end else if (f_eff == '0) begin
                status <= ST_NOROOM;
                done <= 1'b1;
              end else begin
                fr <= '0;
                st <= 4'd0;
                state <= S_CAND;
              end
            end
          end
        end

        // Pick the next candidate, move on to the next frame, or report no room after the last frame.
        S_CAND: begin
          if (st_end > 5'(subframe_count)) begin
            if (fr + FW'(1) == f_eff) begin
              status <= ST_NOROOM;
              done <= 1'b1;
              state <= S_IDLE;
            end else begin
              fr <= fr + FW'(1);
              st <= 4'd0;
            end
          end else if (needc && cand_c == 8'd0) begin
            st <= st + 4'd1;
          end else begin
            smask <= cand_s;
            cmask <= cand_c;
            occ <= fr;
            b <= '0;
            state <= S_CRD;
          end
        end

        S_CRD: begin
          state <= S_CCK;
        end

        // Check one slot of one occurrence.
        S_CCK: begin
          if (fail) begin
            st <= st + 4'd1;
            state <= S_CAND;
          end else if (b_last) begin
            b <= '0;
            if (occ_end) begin
              occ <= fr;
              state <= S_WRD;
            end else begin
              occ <= occ_sum[FW-1:0];
              state <= S_CRD;
            end
          end else begin
            b <= b + BIT_W'(1);
            state <= S_CRD;
          end
        end

        S_WRD: begin
          state <= S_WWR;
        end

        // Commit one slot; finish after the last occurrence.
        S_WWR: begin
          if (b_last) begin
            b <= '0;
            if (occ_end) begin
              status <= ST_OK;
              chosen_frame <= 10'(fr);
              start_mask <= smask;
              complete_mask <= cmask;
              done <= 1'b1;
              state <= S_IDLE;
            end else begin
              occ <= occ_sum[FW-1:0];
              state <= S_WRD;
            end
          end else begin
            b <= b + BIT_W'(1);
            state <= S_WRD;
          end
        end

        // Completion frame of this occurrence.
        S_FMOD: begin
          if (mstat.done) begin
            cf <= mod_rem;
            b <= '0;
            phase <= 1'b0;
            state <= S_FRD;
          end
        end

        S_FRD: begin
          state <= S_FWR;
        end

        // Release the start slot, then the complete slot, of each microframe.
        S_FWR: begin
          state <= S_FRD;
          if (!phase) begin
            phase <= 1'b1;
          end else begin
            phase <= 1'b0;
            if (b_last) begin
              if (occ_end) begin
                done <= 1'b1;
                state <= S_IDLE;
              end else begin
                occ <= occ_sum[FW-1:0];
                mctl.start <= 1'b1;
                state <= S_FMOD;
              end
            end else begin
              b <= b + BIT_W'(1);
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result given without an item in work");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state != S_IDLE))
    else $error("table written while idle");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (start_mask == 8'd0 && complete_mask == 8'd0 &&
                                   chosen_frame == 10'd0))
    else $error("failed allocation carries a reservation");

  a_mod_only_free: assert property (@(posedge clk) disable iff (rst)
    mstat.done |-> (state == S_FMOD))
    else $error("remainder finished outside a free");
`endif

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  import sbr_pkg::*;

  // One request as presented on the input ports.
  typedef struct {
    logic       mode;
    logic [7:0] interval;
    logic [7:0] start_cost;
    logic [7:0] complete_cost;
    logic [3:0] start_runs;
    logic       needs_complete;
    logic [9:0] first_frame;
    logic [7:0] start_mask_in;
    logic [7:0] complete_mask_in;
    logic [9:0] frame_offset_in;
  } request_t;

  // One result as seen on the output ports.
  typedef struct {
    status_t    status;
    logic [9:0] chosen_frame;
    logic [7:0] interval_used;
    logic [7:0] start_mask;
    logic [7:0] complete_mask;
    logic       frame_offset;
  } answer_t;

  // Scoreboard: keeps its own copy of the load table and registers, works out the
  // answer for each accepted item and compares answers in order.
  class reservation_scoreboard;
    logic [7:0] load_table[8192];
    int unsigned enable_reg, frames_reg, subframes_reg, limit_reg;
    answer_t pending[$];
    int mismatches;

    function new();
      foreach (load_table[i]) load_table[i] = 8'd0;
      enable_reg = 1;
      frames_reg = 1024;
      subframes_reg = 8;
      limit_reg = 100;
      mismatches = 0;
    endfunction

    function void note_register(logic [1:0] idx, logic [10:0] data);
      case (idx)
        REG_ENABLE:    enable_reg = data[0];
        REG_FRAMES:    frames_reg = data;
        REG_SUBFRAMES: subframes_reg = data[3:0];
        REG_MAXBW:     limit_reg = data[7:0];
        default: ;
      endcase
    endfunction

    // True when every occurrence of the candidate stays within the limit.
    function bit room_for(int unsigned fr, int unsigned f, int unsigned s, int unsigned iv,
                          logic [7:0] sm, logic [7:0] cm, int unsigned sc, int unsigned cc);
      int unsigned occ, ld;
      for (occ = fr; occ < f; occ += iv)
        for (int b = 0; b < s; b++) begin
          ld = load_table[occ * s + b];
          if (sm[b] && ld + sc > limit_reg) return 0;
          if (cm[b] && ld + cc > limit_reg) return 0;
        end
      return 1;
    endfunction

    function void add_load(int unsigned fr, int unsigned f, int unsigned s, int unsigned iv,
                           logic [7:0] sm, logic [7:0] cm, logic [7:0] sc, logic [7:0] cc);
      for (int unsigned occ = fr; occ < f; occ += iv)
        for (int b = 0; b < s; b++) begin
          if (sm[b]) load_table[occ * s + b] = load_table[occ * s + b] + sc;
          if (cm[b]) load_table[occ * s + b] = load_table[occ * s + b] + cc;
        end
    endfunction

    function void drop_load(int unsigned i, logic [7:0] cost);
      load_table[i] = (load_table[i] > cost) ? load_table[i] - cost : 8'd0;
    endfunction

    // Predicts the answer to one accepted item and updates the table.
    function answer_t note_request(request_t r);
      answer_t a;
      int unsigned f, s, iv, lead, cf;
      logic [7:0] sm, cm;
      bit sub_ok;
      f = (frames_reg > 1024) ? 1024 : frames_reg;
      s = subframes_reg;
      iv = (r.interval == 0) ? 1 : r.interval;
      sub_ok = (s >= 2 && s <= 8);
      a.status = ST_OK;
      a.chosen_frame = '0;
      a.interval_used = iv;
      a.start_mask = '0;
      a.complete_mask = '0;
      a.frame_offset = 1'b0;
      if (r.mode == MODE_FREE) begin
        a.chosen_frame = r.first_frame;
        a.start_mask = r.start_mask_in;
        a.complete_mask = r.complete_mask_in;
        if (sub_ok) begin
          lead = 0;
          while (lead < s && !r.start_mask_in[lead]) lead++;
          for (int unsigned occ = r.first_frame; occ < f; occ += iv) begin
            cf = (occ + r.frame_offset_in + ((lead == s) ? 1 : 0)) % f;
            for (int b = 0; b < s; b++) begin
              if (r.start_mask_in[b]) drop_load(occ * s + b, r.start_cost);
              if (r.complete_mask_in[b]) drop_load(cf * s + b, r.complete_cost);
            end
          end
        end
      end else if (enable_reg == 0 || !sub_ok || r.start_runs == 0 || r.start_runs > s) begin
        a.status = ST_UNSUP;
      end else begin
        a.status = ST_NOROOM;
        for (int unsigned fr = 0; fr < f && a.status != ST_OK; fr++)
          for (int unsigned st = 0; st + r.start_runs <= s && a.status != ST_OK; st++) begin
            sm = '0;
            cm = '0;
            for (int b = 0; b < r.start_runs; b++) sm[st + b] = 1'b1;
            if (r.needs_complete)
              for (int unsigned b = st + r.start_runs + 1; b < s; b++) cm[b] = 1'b1;
            if (!(r.needs_complete && cm == 0) &&
                room_for(fr, f, s, iv, sm, cm, r.start_cost, r.complete_cost)) begin
              add_load(fr, f, s, iv, sm, cm, r.start_cost, r.complete_cost);
              a.status = ST_OK;
              a.chosen_frame = fr;
              a.start_mask = sm;
              a.complete_mask = cm;
            end
          end
      end
      pending.push_back(a);
      return a;
    endfunction

    // Compares one result with the oldest answer waiting.
    function void check_result(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: status %0d", got.status);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.chosen_frame !== want.chosen_frame ||
          got.interval_used !== want.interval_used || got.start_mask !== want.start_mask ||
          got.complete_mask !== want.complete_mask || got.frame_offset !== want.frame_offset)
      begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: exp st %0d fr %0d iv %0d sm %h cm %h fo %0d",
                   want.status, want.chosen_frame, want.interval_used, want.start_mask,
                   want.complete_mask, want.frame_offset);
          $display("          got st %0d fr %0d iv %0d sm %h cm %h fo %0d",
                   got.status, got.chosen_frame, got.interval_used, got.start_mask,
                   got.complete_mask, got.frame_offset);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic mode = 1'b0;
  logic [7:0] interval = '0;
  logic [7:0] start_cost = '0;
  logic [7:0] complete_cost = '0;
  logic [3:0] start_runs = '0;
  logic needs_complete = 1'b0;
  logic [9:0] first_frame = '0;
  logic [7:0] start_mask_in = '0;
  logic [7:0] complete_mask_in = '0;
  logic [9:0] frame_offset_in = '0;
  logic wr_en = 1'b0;
  logic [1:0] wr_index = '0;
  logic [10:0] wr_data = '0;
  logic done;
  logic [1:0] status;
  logic [9:0] chosen_frame;
  logic [7:0] interval_used;
  logic [7:0] start_mask;
  logic [7:0] complete_mask;
  logic frame_offset;

  reservation_scoreboard sb = new();
  request_t held[$];
  bit no_gaps;

  split_bandwidth_reserver uut (.*);

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Results are checked at the edge that ends their strobe cycle.
  always @(posedge clk) begin
    answer_t got;
    if (!rst && done) begin
      got.status = status_t'(status);
      got.chosen_frame = chosen_frame;
      got.interval_used = interval_used;
      got.start_mask = start_mask;
      got.complete_mask = complete_mask;
      got.frame_offset = frame_offset;
      sb.check_result(got);
    end
  end

  // Presents one item and holds it until accepted; start stays high afterward unless a random idle gap follows.
  task automatic send(request_t r);
    answer_t a;
    mode <= r.mode;
    interval <= r.interval;
    start_cost <= r.start_cost;
    complete_cost <= r.complete_cost;
    start_runs <= r.start_runs;
    needs_complete <= r.needs_complete;
    first_frame <= r.first_frame;
    start_mask_in <= r.start_mask_in;
    complete_mask_in <= r.complete_mask_in;
    frame_offset_in <= r.frame_offset_in;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    a = sb.note_request(r);
    // Successful allocations are kept so that later items can release them.
    if (r.mode == MODE_ALLOC && a.status == ST_OK) begin
      r.mode = MODE_FREE;
      r.first_frame = a.chosen_frame;
      r.start_mask_in = a.start_mask;
      r.complete_mask_in = a.complete_mask;
      r.frame_offset_in = '0;
      held.push_back(r);
    end
    // Random idle gap after the item.
    if (!no_gaps && $urandom_range(99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Waits until every answer has come and the block is idle.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    sb.note_register(idx, data);
    wr_en <= 1'b0;
  endtask

  function automatic request_t make_alloc(logic [7:0] iv, logic [3:0] runs, logic nc,
                                          logic [7:0] sc, logic [7:0] cc);
    request_t r;
    r.mode = MODE_ALLOC;
    r.interval = iv;
    r.start_cost = sc;
    r.complete_cost = cc;
    r.start_runs = runs;
    r.needs_complete = nc;
    r.first_frame = $urandom;
    r.start_mask_in = $urandom;
    r.complete_mask_in = $urandom;
    r.frame_offset_in = $urandom;
    return r;
  endfunction

  function automatic request_t make_random();
    request_t r;
    r = make_alloc($urandom, $urandom, $urandom, $urandom, $urandom);
    r.mode = $urandom;
    return r;
  endfunction

  // Mostly well-formed allocations and releases of earlier ones, with some noise.
  function automatic request_t make_item();
    request_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      r = make_alloc($urandom, $urandom_range(1, 4), $urandom, $urandom_range(0, 60),
                     $urandom_range(0, 60));
    end else if (pick < 80 && held.size() != 0) begin
      pick = $urandom_range(held.size() - 1);
      r = held[pick];
      held.delete(pick);
    end else begin
      r = make_random();
    end
    return r;
  endfunction

  // Stimulus.
  initial begin
    request_t r;
    no_gaps = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed items at the reset settings; long intervals keep most searches short.
    send(make_alloc(8'd255, 4'd1, 1'b0, 8'd255, 8'd0));
    send(make_alloc(8'd200, 4'd7, 1'b1, 8'd10, 8'd10));
    send(make_alloc(8'd128, 4'd2, 1'b1, 8'd40, 8'd100));
    send(make_alloc(8'd128, 4'd0, 1'b0, 8'd1, 8'd1));
    send(make_alloc(8'd128, 4'd9, 1'b0, 8'd1, 8'd1));
    send(make_alloc(8'd128, 4'd15, 1'b1, 8'd1, 8'd1));
    send(make_alloc(8'd0, 4'd8, 1'b0, 8'd5, 8'd0));
    while (held.size() != 0) send(held.pop_front());
    r = make_random();
    r.mode = MODE_FREE;
    r.interval = 8'd0;
    r.first_frame = 10'd1023;
    r.start_mask_in = 8'hff;
    r.complete_mask_in = 8'hff;
    r.frame_offset_in = 10'd1023;
    r.start_cost = 8'd255;
    r.complete_cost = 8'd255;
    send(r);
    r.start_mask_in = 8'h00;
    r.frame_offset_in = 10'd0;
    send(r);
    drain();

    // Disabled schedule: allocation is refused, free still works.
    write_reg(REG_ENABLE, 11'd0);
    send(make_alloc(8'd255, 4'd1, 1'b0, 8'd1, 8'd1));
    r.first_frame = 10'd1000;
    send(r);
    drain();
    write_reg(REG_ENABLE, 11'd1);

    // No frames, then a frame count beyond the table.
    write_reg(REG_FRAMES, 11'd0);
    send(make_alloc(8'd1, 4'd1, 1'b0, 8'd1, 8'd1));
    send(r);
    drain();
    write_reg(REG_FRAMES, 11'd2047);
    send(make_alloc(8'd255, 4'd3, 1'b1, 8'd20, 8'd30));
    drain();

    // Unusable microframe counts.
    write_reg(REG_FRAMES, 11'd8);
    write_reg(REG_SUBFRAMES, 11'd1);
    send(make_alloc(8'd1, 4'd1, 1'b0, 8'd1, 8'd1));
    send(r);
    drain();
    write_reg(REG_SUBFRAMES, 11'd15);
    send(make_alloc(8'd1, 4'd1, 1'b0, 8'd1, 8'd1));
    drain();
    held.delete();

    // Random phases over small schedules, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_ENABLE, ($urandom_range(99) < 85) ? 11'd1 : 11'd0);
      write_reg(REG_FRAMES, (ph == 0) ? 11'd1 : (ph == 1) ? 11'd2047 - 11'd1023 - 11'd1008
                                      : $urandom_range(1, 16));
      write_reg(REG_SUBFRAMES, (ph == 1) ? 11'd2 : (ph == 5) ? 11'd8 :
                ($urandom_range(99) < 85) ? $urandom_range(2, 8) : $urandom_range(0, 15));
      write_reg(REG_MAXBW, (ph == 2) ? 11'd0 : (ph == 3) ? 11'd255 : $urandom_range(0, 255));
      no_gaps = (ph == 4);
      repeat (12) send(make_item());
      drain();
      held.delete();
    end

    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
